[rtl/acfm_pkg.sv]
// Shared types and constants for the averaged capture frequency meter.
// Used by acfm_ctrl, acfm_datapath and the top level; depends on nothing.
package acfm_pkg;

  localparam int CAP_W   = 16;                 // timer capture width
  localparam int SUM_W   = 32;                 // period sum and average width
  localparam int IDX_W   = 6;                  // sample index width
  localparam int FREQ_W  = 24;                 // frequency / clock register width
  localparam int DIGIT_W = 4;
  localparam int RANGE_W = 2;
  localparam int NDIG    = 8;                  // BCD digits covering FREQ_W bits
  localparam int BCD_W   = NDIG * DIGIT_W;
  localparam int STEP_W  = $clog2(FREQ_W);     // step counter for divide and BCD
  localparam int OUT_DATA_W = 40;              // 38 payload bits padded to bytes

  localparam logic [FREQ_W-1:0] CLOCK_HZ_RST = 24'd8000000;
  localparam logic [FREQ_W-1:0] KHZ_LIMIT    = 24'd1000;
  localparam logic [FREQ_W-1:0] MHZ_LIMIT    = 24'd1000000;

  // request kinds on in_tuser
  localparam logic REQ_OVERFLOW = 1'b0;
  localparam logic REQ_CAPTURE  = 1'b1;

  // range codes
  localparam logic [RANGE_W-1:0] RANGE_HZ  = 2'd0;
  localparam logic [RANGE_W-1:0] RANGE_KHZ = 2'd1;
  localparam logic [RANGE_W-1:0] RANGE_MHZ = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic take;       // accept the input request this cycle
    logic div_load;   // latch average, start division
    logic div_step;   // one restoring-division step
    logic div_last;   // final division step: keep quotient as frequency
    logic bcd_step;   // one double-dabble step
    logic load_out;   // move the finished result into the output register
  } acfm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic batch_end;  // pending request is the capture that closes a batch
    logic out_free;   // output register can take a result this cycle
  } acfm_sts_t;

endpackage

[rtl/averaged_capture_frequency_meter.sv]
// Averaged capture frequency meter. Overflow ticks and non-final captures are
// accepted one per cycle. The capture that closes a batch of SAMPLE_COUNT
// periods latches the average at its accepting edge. in_tready then stays low for
// 24 steps of a bit-serial restoring divider (clock_hz / average),
// 24 steps of a double-dabble BCD converter for the display digits, and one to
// load the output register; the next request is accepted after that load. A finished
// result waits in the output register and does not stall requests inside the next
// batch. If it is still waiting when the next batch reaches its load step, that
// step holds, and the input stays blocked, until out_tready takes the old result.
// Zero average sets out_tuser and zeroes the rest.
module averaged_capture_frequency_meter import acfm_pkg::*; #(
  parameter int SAMPLE_COUNT = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [FREQ_W-1:0]     cfg_wr_data,  // clock_hz
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CAP_W-1:0]      in_tdata,     // [15:0] capture_value
  input  logic                  in_tuser,     // [0] req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [23:0] freq_hz, [25:24] range_code, [29:26] digit_high,
  // [33:30] digit_mid, [37:34] digit_low, [39:38] zero padding
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser     // [0] zero_period
);

  acfm_cmd_t cmd;
  acfm_sts_t sts;

  acfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  acfm_datapath #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

[rtl/acfm_ctrl.sv]
// Sequencer for the frequency meter: accepts requests, then runs the
// division and BCD steps of a closed batch. Depends on acfm_pkg.
module acfm_ctrl import acfm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  acfm_sts_t sts,
  output acfm_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_BCD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FREQ_W - 1);

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
        if (in_tvalid && sts.batch_end) begin
          cmd.div_load = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          cmd.div_last = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_BCD;
        end
      end
      S_BCD: begin
        cmd.bcd_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          step_nxt  = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register drains
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  a_batch_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_tvalid && sts.batch_end) |=> (state_r == S_DIV))
    else $error("closed batch did not start division");

  a_div_to_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && step_r == LAST_STEP) |=> (state_r == S_BCD && step_r == '0))
    else $error("division did not hand over to BCD conversion");

  a_out_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && sts.out_free) |=> (state_r == S_IDLE))
    else $error("result load did not return to idle");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r <= LAST_STEP))
    else $error("step counter out of range");

endmodule

[rtl/acfm_datapath.sv]
// Datapath for the frequency meter: capture bookkeeping, period sum, restoring
// divider, double-dabble digit conversion and output register. Depends on acfm_pkg.
module acfm_datapath import acfm_pkg::*; #(
  parameter int SAMPLE_COUNT = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [FREQ_W-1:0]     cfg_wr_data,
  input  logic [CAP_W-1:0]      in_tdata,
  input  logic                  in_tuser,
  input  acfm_cmd_t             cmd,
  output acfm_sts_t             sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  // floor(log2(SAMPLE_COUNT))
  localparam int AVG_SHIFT = $clog2(SAMPLE_COUNT + 1) - 1;
  localparam logic [IDX_W:0] BATCH_LEN = (IDX_W + 1)'(SAMPLE_COUNT);

  logic [FREQ_W-1:0] clock_hz_r;
  logic [CAP_W-1:0]  last_r, wrap_r;
  logic [IDX_W-1:0]  idx_r;
  logic [SUM_W-1:0]  sum_r, avg_r;
  logic              zero_r;
  logic [SUM_W-1:0]  rem_r;
  logic [FREQ_W-1:0] q_r, freq_r;
  logic [BCD_W-1:0]  bcd_r;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic              out_zero_r;

  logic [SUM_W-1:0]  period, sum_add, avg_new;
  logic [SUM_W:0]    rem_sh, avg_ext;
  logic              div_ge, qbit;
  logic [SUM_W-1:0]  rem_nxt;
  logic [FREQ_W-1:0] q_div_nxt;
  logic [BCD_W-1:0]  bcd_nxt;
  logic [RANGE_W-1:0] range_code;
  logic [DIGIT_W-1:0] digit_high, digit_mid, digit_low;

  assign period  = {wrap_r, in_tdata} - {{(SUM_W-CAP_W){1'b0}}, last_r};
  assign sum_add = sum_r + period;
  assign avg_new = sum_add >> AVG_SHIFT;

  assign sts.batch_end = (in_tuser == REQ_CAPTURE) &&
                         (({1'b0, idx_r} + 1'b1) == BATCH_LEN);
  assign sts.out_free  = !out_valid_r || out_tready;

  // one restoring step; a zero divisor forces a zero quotient
  assign rem_sh    = {rem_r, q_r[FREQ_W-1]};
  assign avg_ext   = {1'b0, avg_r};
  assign div_ge    = (rem_sh >= avg_ext);
  assign qbit      = div_ge && !zero_r;
  assign rem_nxt   = qbit ? SUM_W'(rem_sh - avg_ext) : rem_sh[SUM_W-1:0];
  assign q_div_nxt = {q_r[FREQ_W-2:0], qbit};

  // double dabble: add 3 to every digit above 4, then shift in the next bit
  always_comb begin
    logic [BCD_W-1:0] adj;
    adj = bcd_r;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end
    end
    bcd_nxt = {adj[BCD_W-2:0], q_r[FREQ_W-1]};
  end

  always_comb begin
    if (freq_r >= MHZ_LIMIT) begin
      range_code = RANGE_MHZ;
      digit_high = bcd_r[7*DIGIT_W +: DIGIT_W];
      digit_mid  = bcd_r[6*DIGIT_W +: DIGIT_W];
      digit_low  = '0;
    end else if (freq_r >= KHZ_LIMIT) begin
      range_code = RANGE_KHZ;
      digit_high = bcd_r[5*DIGIT_W +: DIGIT_W];
      digit_mid  = bcd_r[4*DIGIT_W +: DIGIT_W];
      digit_low  = bcd_r[3*DIGIT_W +: DIGIT_W];
    end else begin
      range_code = RANGE_HZ;
      digit_high = bcd_r[2*DIGIT_W +: DIGIT_W];
      digit_mid  = bcd_r[1*DIGIT_W +: DIGIT_W];
      digit_low  = bcd_r[0 +: DIGIT_W];
    end
  end

  // measurement state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLOCK_HZ_RST;
      last_r     <= '0;
      wrap_r     <= '0;
      idx_r      <= '0;
      sum_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        clock_hz_r <= cfg_wr_data;
      end
      if (cmd.take) begin
        if (in_tuser == REQ_OVERFLOW) begin
          wrap_r <= wrap_r + 1'b1;
        end else begin
          last_r <= in_tdata;
          wrap_r <= '0;
          if (sts.batch_end) begin
            sum_r <= '0;
            idx_r <= '0;
          end else begin
            sum_r <= sum_add;
            idx_r <= idx_r + 1'b1;
          end
        end
      end
    end
  end

  // divider and conversion working registers
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      avg_r  <= avg_new;
      zero_r <= (avg_new == '0);
      q_r    <= clock_hz_r;
      rem_r  <= '0;
      bcd_r  <= '0;
    end else if (cmd.div_step) begin
      q_r   <= q_div_nxt;
      rem_r <= rem_nxt;
      if (cmd.div_last) begin
        freq_r <= q_div_nxt;
      end
    end else if (cmd.bcd_step) begin
      q_r   <= {q_r[FREQ_W-2:0], 1'b0};
      bcd_r <= bcd_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {2'b00, digit_low, digit_mid, digit_high, range_code, freq_r};
      out_zero_r <= zero_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

  a_zero_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zero_r) |-> (out_data_r[FREQ_W+RANGE_W-1:0] == '0))
    else $error("zero period result carries nonzero frequency");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending one");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> !(cmd.div_step || cmd.bcd_step || cmd.load_out))
    else $error("request taken during a conversion");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for averaged_capture_frequency_meter: drives overflow ticks
// and captures, predicts each batch report and checks it. Depends on acfm_pkg.
module tb;
  import acfm_pkg::*;

  localparam int SAMPLE_COUNT = 8;
  // floor(log2(SAMPLE_COUNT))
  localparam int AVG_SHIFT = $clog2(SAMPLE_COUNT + 1) - 1;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [FREQ_W-1:0]  freq_hz;
    logic [RANGE_W-1:0] range_code;
    logic [DIGIT_W-1:0] digit_high;
    logic [DIGIT_W-1:0] digit_mid;
    logic [DIGIT_W-1:0] digit_low;
    logic               zero_period;
  } freq_report_t;

  class freq_report_tracker;
    logic [FREQ_W-1:0] clock_hz = CLOCK_HZ_RST;
    logic [CAP_W-1:0]  last_capture = '0;
    logic [CAP_W-1:0]  wrap_count = '0;
    logic [IDX_W-1:0]  sample_index = '0;
    logic [SUM_W-1:0]  period_sum = '0;
    freq_report_t      expected_reports[$];
    int                errors = 0;

    function int pending();
      return expected_reports.size();
    endfunction

    // Advance the meter state by one request; queue a report when a batch closes.
    function void note_request(logic kind, logic [CAP_W-1:0] value);
      logic [SUM_W-1:0] period;
      logic [SUM_W-1:0] avg;
      logic [SUM_W-1:0] f;
      freq_report_t     rep;
      if (kind == REQ_OVERFLOW) begin
        wrap_count = wrap_count + 1'b1;
        return;
      end
      period = {wrap_count, 16'h0000} + SUM_W'(value) - SUM_W'(last_capture);
      last_capture = value;
      wrap_count = '0;
      period_sum = period_sum + period;
      sample_index = sample_index + 1'b1;
      if (sample_index < SAMPLE_COUNT && sample_index != 0) return;
      avg = period_sum >> AVG_SHIFT;
      period_sum = '0;
      sample_index = '0;
      rep = '0;
      if (avg == 0) begin
        rep.zero_period = 1'b1;
      end else begin
        f = SUM_W'(clock_hz) / avg;
        rep.freq_hz = f[FREQ_W-1:0];
        if (f >= MHZ_LIMIT) begin
          rep.range_code = RANGE_MHZ;
          rep.digit_high = DIGIT_W'(f / 10000000);
          rep.digit_mid  = DIGIT_W'((f % 10000000) / 1000000);
        end else if (f >= KHZ_LIMIT) begin
          rep.range_code = RANGE_KHZ;
          rep.digit_high = DIGIT_W'(f / 100000);
          rep.digit_mid  = DIGIT_W'((f % 100000) / 10000);
          rep.digit_low  = DIGIT_W'((f % 10000) / 1000);
        end else begin
          rep.range_code = RANGE_HZ;
          rep.digit_high = DIGIT_W'(f / 100);
          rep.digit_mid  = DIGIT_W'((f % 100) / 10);
          rep.digit_low  = DIGIT_W'(f % 10);
        end
      end
      expected_reports.push_back(rep);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] tdata, logic tuser);
      freq_report_t exp_rep;
      if (expected_reports.size() == 0) begin
        $error("report with no request pending: tdata %h tuser %b", tdata, tuser);
        errors++;
        return;
      end
      exp_rep = expected_reports.pop_front();
      compare_field("freq_hz", exp_rep.freq_hz, tdata[23:0]);
      compare_field("range_code", exp_rep.range_code, tdata[25:24]);
      compare_field("digit_high", exp_rep.digit_high, tdata[29:26]);
      compare_field("digit_mid", exp_rep.digit_mid, tdata[33:30]);
      compare_field("digit_low", exp_rep.digit_low, tdata[37:34]);
      compare_field("zero_period", exp_rep.zero_period, tuser);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [FREQ_W-1:0]     cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [CAP_W-1:0]      in_tdata = '0;   // [15:0] capture_value
  logic                  in_tuser = 1'b0; // [0] req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [23:0] freq_hz, [25:24] range_code, [29:26] digit_high,
  // [33:30] digit_mid, [37:34] digit_low, [39:38] zero padding
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;       // [0] zero_period

  freq_report_tracker board = new();

  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_cycles = 0;
  int               requests_sent = 0;
  logic [CAP_W-1:0] gen_last = '0;

  averaged_capture_frequency_meter #(.SAMPLE_COUNT(SAMPLE_COUNT)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always #4 clk = ~clk;

  // Receiver: long hold-off when asked, random stalls otherwise.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
  end

  task automatic send_request(logic kind, logic [CAP_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    board.note_request(kind, value);
    requests_sent++;
    if (kind == REQ_CAPTURE) gen_last = value;
  endtask

  // Emit the overflow ticks and the capture that make one period of the given length.
  task automatic send_period(logic [SUM_W-1:0] period);
    logic [SUM_W:0] target;
    int             wraps;
    target = {17'd0, gen_last} + {1'b0, period};
    wraps = int'(target[SUM_W:16]);
    repeat (wraps) send_request(REQ_OVERFLOW, CAP_W'($urandom()));
    send_request(REQ_CAPTURE, target[15:0]);
  endtask

  // Hold the sender until every report is out and the block has settled.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_clock(logic [FREQ_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    board.clock_hz = value;
  endtask

  task automatic run_random(int n_requests);
    int goal;
    int pick;
    goal = requests_sent + n_requests;
    while (requests_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 10)      send_period($urandom_range(24));
      else if (pick < 35) send_period($urandom_range(20000, 25));
      else if (pick < 60) send_period($urandom_range(200000, 20000));
      else if (pick < 66) send_period($urandom_range(1 << 22, 200000));
      else if (pick < 85) begin
        // broken timing: zero to two ticks and an arbitrary capture
        repeat ($urandom_range(2)) send_request(REQ_OVERFLOW, CAP_W'($urandom()));
        send_request(REQ_CAPTURE, CAP_W'($urandom()));
      end else begin
        send_request(REQ_OVERFLOW, CAP_W'($urandom()));
      end
    end
  endtask

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 23;
    recv_idle_pct = 54;

    // zero average at the reset clock
    repeat (SAMPLE_COUNT) send_request(REQ_CAPTURE, 16'h0000);
    drain();
    // unit periods at the top clock: MHz range
    write_clock(24'd16000000);
    for (int i = 1; i <= SAMPLE_COUNT; i++) send_request(REQ_CAPTURE, CAP_W'(i));
    drain();
    // clock register zero, with a tick and a full-scale capture
    write_clock('0);
    send_request(REQ_OVERFLOW, 16'hFFFF);
    send_request(REQ_CAPTURE, 16'hFFFF);
    repeat (SAMPLE_COUNT - 1) send_request(REQ_CAPTURE, CAP_W'($urandom()));
    drain();

    write_clock(24'd16000000);
    hold_cycles = 3000;
    run_random(600);
    drain();

    send_idle_pct = 54;
    recv_idle_pct = 23;
    write_clock(FREQ_W'($urandom_range(16000000, 1)));
    run_random(600);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_clock(24'd1);
    run_random(300);
    drain();
    write_clock(FREQ_W'($urandom_range(16000000, 1)));
    run_random(300);
    drain();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/acfm_pkg.sv
rtl/acfm_ctrl.sv
rtl/acfm_datapath.sv
rtl/averaged_capture_frequency_meter.sv
test/tb.sv
